// File: hdl/ral_pkg.sv
// ----------------------------------------------------------------------------
// ral_pkg
// Shared types and constants of the record array list: capacity, index and
// count widths, request codes, the record layout and the command and status
// groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package ral_pkg;

   localparam int CAPACITY = 16;
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int POS_W    = 5;
   localparam int OP_W     = 3;
   localparam int KEY_W    = 31;
   localparam int CMP_W    = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

   typedef enum logic [OP_W-1:0] {
      OP_INS_FRONT = 3'd0,
      OP_INS_REAR  = 3'd1,
      OP_INS_AT    = 3'd2,
      OP_DEL_FRONT = 3'd3,
      OP_DEL_REAR  = 3'd4,
      OP_DEL_AT    = 3'd5,
      OP_DEL_KEY   = 3'd6,
      OP_FIND      = 3'd7
   } op_type;

   typedef struct packed {
      logic [KEY_W-1:0] key_id;
      logic [6:0]       age;
      logic             gender;
      logic [3:0]       birth_month;
      logic [4:0]       birth_day;
      logic [11:0]      birth_year;
   } rec_type;

   localparam int REC_W = $bits(rec_type);

   // Commands from the controller to the datapath for one cycle.
   typedef struct packed {
      logic             load;     // capture the incoming record
      logic             rd_en;    // read one stored entry
      logic [IDX_W-1:0] rd_addr;
      logic             mv_en;    // write the entry read now back at mv_addr next cycle
      logic [IDX_W-1:0] mv_addr;
      logic             wr_en;    // write the captured record
      logic [IDX_W-1:0] wr_addr;
   } cmd_type;

   typedef struct packed {
      logic key_match;            // entry read last cycle carries the captured key
   } status_type;

endpackage

// File: hdl/record_array_list.sv
// ----------------------------------------------------------------------------
// record_array_list
// Fixed-capacity ordered list of records with insert, delete and key search.
// ----------------------------------------------------------------------------
// One request is taken at a time and gives one result. Records live in a RAM
// with one registered read port, so every shift or key scan moves through the
// stored entries one per cycle. An insert below the fill level first moves the
// later entries up one slot, and a delete below the last entry, by index or by
// key, moves the later entries down one slot; an append or a delete of the last
// entry moves nothing. A finished result waits in its register while the next
// request is taken; a second result waits in the controller until the first
// transfer out, and the input stays stalled until then. The store needs no
// clearing after reset: only entries below the fill level are ever read.
// ----------------------------------------------------------------------------
module record_array_list
   import ral_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [OP_W-1:0]  req_op,
   input  logic [POS_W-1:0] req_position,
   input  logic [KEY_W-1:0] req_key_id,
   input  logic [6:0]       req_age,
   input  logic             req_gender,
   input  logic [3:0]       req_birth_month,
   input  logic [4:0]       req_birth_day,
   input  logic [11:0]      req_birth_year,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic             rsp_ok,
   output logic             rsp_found,
   output logic [IDX_W-1:0] rsp_found_position,
   output logic [CNT_W-1:0] rsp_entry_count
);

   rec_type    rec;
   cmd_type    cmd;
   status_type status;

   assign rec.key_id      = req_key_id;
   assign rec.age         = req_age;
   assign rec.gender      = req_gender;
   assign rec.birth_month = req_birth_month;
   assign rec.birth_day   = req_birth_day;
   assign rec.birth_year  = req_birth_year;

   ral_ctrl u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_op             (req_op),
      .req_position       (req_position),
      .cmd                (cmd),
      .status             (status),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_ok             (rsp_ok),
      .rsp_found          (rsp_found),
      .rsp_found_position (rsp_found_position),
      .rsp_entry_count    (rsp_entry_count)
   );

   ral_datapath u_datapath (
      .clock  (clock),
      .rec    (rec),
      .cmd    (cmd),
      .status (status)
   );

endmodule

// File: hdl/ral_ram.sv
// ----------------------------------------------------------------------------
// ral_ram
// Generic simple dual-port RAM: one write port and one read port with a
// registered read.
// ----------------------------------------------------------------------------
module ral_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/ral_datapath.sv
// ----------------------------------------------------------------------------
// ral_datapath
// Record storage and data movement: holds the incoming record, moves entries
// one slot per cycle through the RAM and compares stored keys.
// ----------------------------------------------------------------------------
module ral_datapath
   import ral_pkg::*;
(
   input  logic       clock,
   input  rec_type    rec,
   input  cmd_type    cmd,
   output status_type status
);

   rec_type          rec_ff;
   logic             mv_ff;
   logic [IDX_W-1:0] mv_addr_ff;
   rec_type          rd_data;
   logic [REC_W-1:0] rd_bits;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [REC_W-1:0] wr_data;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rec_ff <= rec;
      end
      mv_ff      <= cmd.mv_en;
      mv_addr_ff <= cmd.mv_addr;
   end

   // A pending move has the write port; the controller never asks for a
   // record write in the same cycle.
   assign wr_en   = mv_ff | cmd.wr_en;
   assign wr_addr = mv_ff ? mv_addr_ff : cmd.wr_addr;
   assign wr_data = mv_ff ? rd_bits : rec_ff;

   ral_ram #(
      .WIDTH (REC_W),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (cmd.rd_addr),
      .rd_data (rd_bits)
   );

   assign rd_data          = rec_type'(rd_bits);
   assign status.key_match = (rd_data.key_id == rec_ff.key_id);

endmodule

// File: hdl/ral_ctrl.sv
// ----------------------------------------------------------------------------
// ral_ctrl
// Request sequencer: checks each request against the fill level, steps the
// shift and key scan one entry per cycle and holds the result register.
// ----------------------------------------------------------------------------
module ral_ctrl
   import ral_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [OP_W-1:0]  req_op,
   input  logic [POS_W-1:0] req_position,
   output cmd_type          cmd,
   input  status_type       status,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic             rsp_ok,
   output logic             rsp_found,
   output logic [IDX_W-1:0] rsp_found_position,
   output logic [CNT_W-1:0] rsp_entry_count
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SEARCH,
      S_SHIFT_UP,
      S_DRAIN_UP,
      S_PUT,
      S_SHIFT_DN,
      S_DRAIN_DN,
      S_DONE
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [CNT_W-1:0] ptr_ff, ptr_in;
   logic [IDX_W-1:0] at_ff, at_in;
   op_type           op_ff, op_in;
   logic             chk_ff, chk_in;
   logic [IDX_W-1:0] chk_addr_ff, chk_addr_in;
   logic             ok_ff, ok_in;
   logic             found_ff, found_in;
   logic [IDX_W-1:0] where_ff, where_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_ok_ff, rsp_ok_in;
   logic             rsp_found_ff, rsp_found_in;
   logic [IDX_W-1:0] rsp_where_ff, rsp_where_in;
   logic [CNT_W-1:0] rsp_count_ff, rsp_count_in;

   logic [CMP_W-1:0] fill_x;
   logic [CMP_W-1:0] pos_x;
   logic [CMP_W-1:0] at_sel;
   logic [CMP_W-1:0] chk_x;
   logic             ins_ok;
   logic             del_ok;

   assign fill_x = CMP_W'(fill_ff);
   assign pos_x  = CMP_W'(req_position);
   assign chk_x  = CMP_W'(chk_addr_ff);

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      ptr_in       = ptr_ff;
      at_in        = at_ff;
      op_in        = op_ff;
      chk_in       = 1'b0;
      chk_addr_in  = chk_addr_ff;
      ok_in        = ok_ff;
      found_in     = found_ff;
      where_in     = where_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_ok_in    = rsp_ok_ff;
      rsp_found_in = rsp_found_ff;
      rsp_where_in = rsp_where_ff;
      rsp_count_in = rsp_count_ff;
      at_sel       = '0;
      ins_ok       = 1'b0;
      del_ok       = 1'b0;
      cmd          = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               op_in    = op_type'(req_op);
               ok_in    = 1'b0;
               found_in = 1'b0;
               where_in = '0;
               ptr_in   = '0;
               unique case (op_type'(req_op))
                  OP_INS_FRONT, OP_INS_REAR, OP_INS_AT: begin
                     case (op_type'(req_op))
                        OP_INS_FRONT: at_sel = '0;
                        OP_INS_REAR:  at_sel = fill_x;
                        default:      at_sel = pos_x;
                     endcase
                     ins_ok = (fill_ff != CNT_W'(CAPACITY)) && (at_sel <= fill_x);
                     at_in  = at_sel[IDX_W-1:0];
                     if (ins_ok) begin
                        ok_in   = 1'b1;
                        fill_in = fill_ff + 1'b1;
                        if (fill_x > at_sel) begin
                           ptr_in   = fill_ff - 1'b1;
                           state_in = S_SHIFT_UP;
                        end else begin
                           state_in = S_PUT;
                        end
                     end else begin
                        state_in = S_DONE;
                     end
                  end
                  OP_DEL_FRONT, OP_DEL_REAR, OP_DEL_AT: begin
                     case (op_type'(req_op))
                        OP_DEL_FRONT: at_sel = '0;
                        OP_DEL_REAR:  at_sel = fill_x - 1'b1;
                        default:      at_sel = pos_x;
                     endcase
                     del_ok = (fill_ff != '0) && (at_sel < fill_x);
                     at_in  = at_sel[IDX_W-1:0];
                     if (del_ok) begin
                        ok_in   = 1'b1;
                        fill_in = fill_ff - 1'b1;
                        ptr_in  = CNT_W'(at_sel + 1'b1);
                        if ((at_sel + 1'b1) < fill_x) begin
                           state_in = S_SHIFT_DN;
                        end else begin
                           state_in = S_DONE;
                        end
                     end else begin
                        state_in = S_DONE;
                     end
                  end
                  OP_DEL_KEY, OP_FIND: begin
                     state_in = S_SEARCH;
                  end
               endcase
            end
         end

         // One read issued per cycle; the key of the entry read in the previous
         // cycle is checked, so the first match stops the scan.
         S_SEARCH: begin
            if (chk_ff && status.key_match) begin
               found_in = 1'b1;
               where_in = chk_addr_ff;
               if (op_ff == OP_DEL_KEY) begin
                  ok_in   = 1'b1;
                  at_in   = chk_addr_ff;
                  fill_in = fill_ff - 1'b1;
                  ptr_in  = CNT_W'(chk_x + 1'b1);
                  if ((chk_x + 1'b1) < fill_x) begin
                     state_in = S_SHIFT_DN;
                  end else begin
                     state_in = S_DONE;
                  end
               end else begin
                  ok_in    = 1'b1;
                  state_in = S_DONE;
               end
            end else if (ptr_ff < fill_ff) begin
               cmd.rd_en   = 1'b1;
               cmd.rd_addr = ptr_ff[IDX_W-1:0];
               chk_in      = 1'b1;
               chk_addr_in = ptr_ff[IDX_W-1:0];
               ptr_in      = ptr_ff + 1'b1;
            end else begin
               ok_in    = (op_ff == OP_FIND);
               state_in = S_DONE;
            end
         end

         S_SHIFT_UP: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_addr = ptr_ff[IDX_W-1:0];
            cmd.mv_en   = 1'b1;
            cmd.mv_addr = ptr_ff[IDX_W-1:0] + 1'b1;
            if (ptr_ff[IDX_W-1:0] == at_ff) begin
               state_in = S_DRAIN_UP;
            end else begin
               ptr_in = ptr_ff - 1'b1;
            end
         end

         S_DRAIN_UP: begin
            state_in = S_PUT;
         end

         S_PUT: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_addr = at_ff;
            state_in    = S_DONE;
         end

         // The fill level is already reduced, so the last entry to move sits
         // at the new fill level.
         S_SHIFT_DN: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_addr = ptr_ff[IDX_W-1:0];
            cmd.mv_en   = 1'b1;
            cmd.mv_addr = ptr_ff[IDX_W-1:0] - 1'b1;
            if (ptr_ff == fill_ff) begin
               state_in = S_DRAIN_DN;
            end else begin
               ptr_in = ptr_ff + 1'b1;
            end
         end

         S_DRAIN_DN: begin
            state_in = S_DONE;
         end

         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = ok_ff;
               rsp_found_in = found_ff;
               rsp_where_in = where_ff;
               rsp_count_in = fill_ff;
               state_in     = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         chk_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         chk_ff       <= chk_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ptr_ff       <= ptr_in;
      at_ff        <= at_in;
      op_ff        <= op_in;
      chk_addr_ff  <= chk_addr_in;
      ok_ff        <= ok_in;
      found_ff     <= found_in;
      where_ff     <= where_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_found_ff <= rsp_found_in;
      rsp_where_ff <= rsp_where_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign req_stall          = (state_ff != S_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_ok             = rsp_ok_ff;
   assign rsp_found          = rsp_found_ff;
   assign rsp_found_position = rsp_where_ff;
   assign rsp_entry_count    = rsp_count_ff;

endmodule
